@@ rtl/core/aar_pkg.sv @@
// Shared constants for the axis-angle rotation matrix pipeline.
// No dependencies.
package aar_pkg;

  // default fraction bits of the Q format (1.0 = 2^FRAC_BITS)
  localparam int unsigned DefFracBits = 14;
  // width of every input and result field
  localparam int unsigned DataW       = 16;
  // width of the integer square root result
  localparam int unsigned RootW       = 32;

endpackage

@@ rtl/core/aar_sqrt.sv @@
// Pipelined squared-length and integer square root, one root bit per stage.
// Depends on aar_pkg.
module aar_sqrt #(
  parameter int unsigned SideW = 80
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [aar_pkg::DataW-1:0] axis_x_i,
  input  logic signed [aar_pkg::DataW-1:0] axis_y_i,
  input  logic signed [aar_pkg::DataW-1:0] axis_z_i,
  input  logic [SideW-1:0]              side_i,
  output logic                          valid_o,
  output logic [aar_pkg::RootW-1:0]     root_o,
  output logic [SideW-1:0]              side_o
);

  localparam int unsigned Steps = aar_pkg::RootW;
  localparam int unsigned RemW  = 2 * aar_pkg::RootW + 2;

  logic signed [2*aar_pkg::DataW-1:0] sq_x, sq_y, sq_z;
  logic [aar_pkg::RootW+1:0]          n2;

  logic [Steps:0]            vld_q;
  logic [RemW-1:0]           rem_q  [Steps+1];
  logic [aar_pkg::RootW-1:0] root_q [Steps+1];
  logic [SideW-1:0]          side_q [Steps+1];

  // squared length, exact
  assign sq_x = axis_x_i * axis_x_i;
  assign sq_y = axis_y_i * axis_y_i;
  assign sq_z = axis_z_i * axis_z_i;
  assign n2   = (aar_pkg::RootW+2)'(unsigned'(sq_x)) + (aar_pkg::RootW+2)'(unsigned'(sq_y))
              + (aar_pkg::RootW+2)'(unsigned'(sq_z));

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-1:0], valid_i};
    end
  end

  // entry stage: radicand is n2 * 2^32
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= RemW'({n2, {aar_pkg::RootW{1'b0}}});
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  // one root bit per stage, most significant first
  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int unsigned Bit = Steps - 1 - k;
    logic [RemW-1:0] trial;
    logic            ge;
    assign trial = (RemW'(root_q[k]) << (Bit + 1)) | (RemW'(1) << (2 * Bit));
    assign ge    = rem_q[k] >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? rem_q[k] - trial : rem_q[k];
        root_q[k+1] <= root_q[k] | (aar_pkg::RootW'(ge) << Bit);
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign root_o  = root_q[Steps];
  assign side_o  = side_q[Steps];

endmodule

@@ rtl/core/aar_div.sv @@
// Pipelined restoring divider: unit axis = axis * 2^(FRAC_BITS+16) / root, rounded.
// Depends on aar_pkg.
module aar_div #(
  parameter int unsigned FracBits = aar_pkg::DefFracBits,
  parameter int unsigned SideW    = 33,
  localparam int unsigned UnitW   = FracBits + 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [aar_pkg::RootW-1:0]        root_i,
  input  logic signed [aar_pkg::DataW-1:0] axis_x_i,
  input  logic signed [aar_pkg::DataW-1:0] axis_y_i,
  input  logic signed [aar_pkg::DataW-1:0] axis_z_i,
  input  logic [SideW-1:0]                 side_i,
  output logic                             valid_o,
  output logic signed [UnitW-1:0]          unit_x_o,
  output logic signed [UnitW-1:0]          unit_y_o,
  output logic signed [UnitW-1:0]          unit_z_o,
  output logic [SideW-1:0]                 side_o
);

  // quotient stays below 2^(FracBits+2)
  localparam int unsigned QuoW = FracBits + 2;
  localparam int unsigned NumW = FracBits + 33;
  localparam int unsigned MagW = aar_pkg::DataW + 1;

  logic signed [aar_pkg::DataW-1:0] axis_in [3];
  logic [MagW-1:0]                  mag     [3];

  logic [QuoW:0]             vld_q;
  logic [NumW-1:0]           rem_q  [QuoW+1][3];
  logic [QuoW-1:0]           quo_q  [QuoW+1][3];
  logic                      neg_q  [QuoW+1][3];
  logic [aar_pkg::RootW-1:0] den_q  [QuoW+1];
  logic [SideW-1:0]          side_q [QuoW+1];
  logic signed [UnitW-1:0]   unit   [3];

  assign axis_in[0] = axis_x_i;
  assign axis_in[1] = axis_y_i;
  assign axis_in[2] = axis_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuoW-1:0], valid_i};
    end
  end

  // entry stage: magnitude numerator with half the divisor added
  for (genvar j = 0; j < 3; j++) begin : g_in
    assign mag[j] = axis_in[j][aar_pkg::DataW-1] ? (~{1'b1, axis_in[j]} + 1'b1)
                                                 : {1'b0, axis_in[j]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0][j] <= (NumW'(mag[j]) << (FracBits + 16)) + NumW'(root_i >> 1);
        quo_q[0][j] <= '0;
        neg_q[0][j] <= axis_in[j][aar_pkg::DataW-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= root_i;
      side_q[0] <= side_i;
    end
  end

  // one quotient bit per stage for all three components
  for (genvar k = 0; k < QuoW; k++) begin : g_step
    localparam int unsigned Bit = QuoW - 1 - k;
    logic [NumW-1:0] dsh;
    assign dsh = NumW'(den_q[k]) << Bit;
    for (genvar j = 0; j < 3; j++) begin : g_comp
      logic ge;
      assign ge = rem_q[k][j] >= dsh;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1][j] <= ge ? rem_q[k][j] - dsh : rem_q[k][j];
          quo_q[k+1][j] <= quo_q[k][j] | (QuoW'(ge) << Bit);
          neg_q[k+1][j] <= neg_q[k][j];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // restore sign
  for (genvar j = 0; j < 3; j++) begin : g_out
    assign unit[j] = neg_q[QuoW][j] ? -signed'({1'b0, quo_q[QuoW][j]})
                                    :  signed'({1'b0, quo_q[QuoW][j]});
  end

  assign valid_o  = vld_q[QuoW];
  assign unit_x_o = unit[0];
  assign unit_y_o = unit[1];
  assign unit_z_o = unit[2];
  assign side_o   = side_q[QuoW];

endmodule

@@ rtl/core/aar_mat.sv @@
// Matrix stages: axis products, scale by (1 - cos), sums and saturation.
// Depends on aar_pkg.
module aar_mat #(
  parameter int unsigned FracBits = aar_pkg::DefFracBits,
  localparam int unsigned UnitW   = FracBits + 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [UnitW-1:0]          unit_x_i,
  input  logic signed [UnitW-1:0]          unit_y_i,
  input  logic signed [UnitW-1:0]          unit_z_i,
  input  logic signed [aar_pkg::DataW-1:0] cos_i,
  input  logic signed [aar_pkg::DataW-1:0] sin_i,
  input  logic                             zero_i,
  output logic                             valid_o,
  output logic signed [aar_pkg::DataW-1:0] ent_o [9],
  output logic                             zero_o
);

  localparam int unsigned PrW  = 2 * UnitW;
  localparam int unsigned SpW  = UnitW + aar_pkg::DataW;
  localparam int unsigned SkW  = aar_pkg::DataW + 2;
  localparam int unsigned TW   = ((FracBits > aar_pkg::DataW) ? FracBits : aar_pkg::DataW) + 2;
  localparam int unsigned QpW  = UnitW + TW;
  localparam int unsigned QW   = TW + 1;
  localparam int unsigned EW   = QW + 2;

  localparam logic signed [PrW-1:0] HalfPr = PrW'(1) << (FracBits - 1);
  localparam logic signed [SpW-1:0] HalfSp = SpW'(1) << (FracBits - 1);
  localparam logic signed [QpW-1:0] HalfQp = QpW'(1) << (FracBits - 1);
  localparam logic signed [TW-1:0]  OneT   = TW'(1) << FracBits;
  localparam logic signed [EW-1:0]  SatHi  = EW'(32'sd32767);
  localparam logic signed [EW-1:0]  SatLo  = EW'(-32'sd32768);

  // product order: xx yy zz xy xz yz
  logic signed [UnitW-1:0] ua [6], ub [6], u [3];
  logic signed [PrW-1:0]   pr [6];
  logic signed [SpW-1:0]   sp [3];

  logic [2:0]                       vld_q;
  logic signed [UnitW-1:0]          p_q  [6];
  logic signed [SkW-1:0]            sk_q [3], sk2_q [3];
  logic signed [TW-1:0]             t_q;
  logic signed [aar_pkg::DataW-1:0] c_q, c2_q;
  logic                             z_q, z2_q;
  logic signed [QW-1:0]             q_q  [6];
  logic signed [QpW-1:0]            qp   [6];
  logic signed [EW-1:0]             sum  [9];

  function automatic logic signed [aar_pkg::DataW-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    r = v;
    if (v > SatHi) r = SatHi;
    if (v < SatLo) r = SatLo;
    return aar_pkg::DataW'(r);
  endfunction

  assign u[0] = unit_x_i;
  assign u[1] = unit_y_i;
  assign u[2] = unit_z_i;
  assign ua = '{u[0], u[1], u[2], u[0], u[0], u[1]};
  assign ub = '{u[0], u[1], u[2], u[1], u[2], u[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // stage A: rounded axis products and sine terms
  for (genvar i = 0; i < 6; i++) begin : g_pa
    assign pr[i] = ua[i] * ub[i];
    always_ff @(posedge clk_i) begin
      if (en_i) p_q[i] <= UnitW'((pr[i] + HalfPr) >>> FracBits);
    end
  end
  for (genvar k = 0; k < 3; k++) begin : g_sk
    assign sp[k] = u[k] * sin_i;
    always_ff @(posedge clk_i) begin
      if (en_i) sk_q[k] <= SkW'((sp[k] + HalfSp) >>> FracBits);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= OneT - TW'(cos_i);
      c_q <= cos_i;
      z_q <= zero_i;
    end
  end

  // stage B: scale by t = 1 - cos
  for (genvar i = 0; i < 6; i++) begin : g_pb
    assign qp[i] = p_q[i] * t_q;
    always_ff @(posedge clk_i) begin
      if (en_i) q_q[i] <= QW'((qp[i] + HalfQp) >>> FracBits);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sk2_q <= sk_q;
      c2_q  <= c_q;
      z2_q  <= z_q;
    end
  end

  // stage C: Rodrigues sums, saturate, force zero for a null axis
  assign sum[0] = EW'(q_q[0]) + EW'(c2_q);
  assign sum[1] = EW'(q_q[3]) - EW'(sk2_q[2]);
  assign sum[2] = EW'(q_q[4]) + EW'(sk2_q[1]);
  assign sum[3] = EW'(q_q[3]) + EW'(sk2_q[2]);
  assign sum[4] = EW'(q_q[1]) + EW'(c2_q);
  assign sum[5] = EW'(q_q[5]) - EW'(sk2_q[0]);
  assign sum[6] = EW'(q_q[4]) - EW'(sk2_q[1]);
  assign sum[7] = EW'(q_q[5]) + EW'(sk2_q[0]);
  assign sum[8] = EW'(q_q[2]) + EW'(c2_q);

  for (genvar e = 0; e < 9; e++) begin : g_out
    always_ff @(posedge clk_i) begin
      if (en_i) ent_o[e] <= z2_q ? '0 : sat(sum[e]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) zero_o <= z2_q;
  end

  assign valid_o = vld_q[2];

endmodule

@@ rtl/core/axis_angle_rotation_matrix.sv @@
// Top level: Rodrigues axis-angle to 3x3 rotation matrix, Q(FRAC_BITS) fixed point.
// Depends on aar_pkg, aar_sqrt, aar_div, aar_mat.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid_i/in_ready_o | cos_value_i sin_value_i axis_x_i/y/z
//  out     | out_valid_o/out_ready_i | r0c0_o .. r2c2_o axis_zero_o
//
// One item per cycle while the output is not stalled. The pipeline holds 32 square
// root stages plus entry, one divider stage per quotient bit plus entry,
// then three matrix stages. The whole pipeline advances together; when the
// output register holds an untaken item, in_ready_o drops and every stage
// holds. Reset clears only the valid bits.
module axis_angle_rotation_matrix #(
  parameter int unsigned FRAC_BITS = aar_pkg::DefFracBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [aar_pkg::DataW-1:0] cos_value_i,
  input  logic signed [aar_pkg::DataW-1:0] sin_value_i,
  input  logic signed [aar_pkg::DataW-1:0] axis_x_i,
  input  logic signed [aar_pkg::DataW-1:0] axis_y_i,
  input  logic signed [aar_pkg::DataW-1:0] axis_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [aar_pkg::DataW-1:0] r0c0_o,
  output logic signed [aar_pkg::DataW-1:0] r0c1_o,
  output logic signed [aar_pkg::DataW-1:0] r0c2_o,
  output logic signed [aar_pkg::DataW-1:0] r1c0_o,
  output logic signed [aar_pkg::DataW-1:0] r1c1_o,
  output logic signed [aar_pkg::DataW-1:0] r1c2_o,
  output logic signed [aar_pkg::DataW-1:0] r2c0_o,
  output logic signed [aar_pkg::DataW-1:0] r2c1_o,
  output logic signed [aar_pkg::DataW-1:0] r2c2_o,
  output logic                             axis_zero_o
);

  localparam int unsigned DW    = aar_pkg::DataW;
  localparam int unsigned SqSW  = 5 * DW;
  localparam int unsigned DvSW  = 2 * DW + 1;
  localparam int unsigned UnitW = FRAC_BITS + 3;

  logic                      en;
  logic                      sq_vld, dv_vld, mat_vld;
  logic [SqSW-1:0]           sq_side_in, sq_side;
  logic [aar_pkg::RootW-1:0] root;
  logic [DvSW-1:0]           dv_side_in, dv_side;
  logic signed [UnitW-1:0]   ux, uy, uz;
  logic signed [DW-1:0]      ent [9];

  // global advance: move unless a finished item waits untaken
  assign en         = !mat_vld || out_ready_i;
  assign in_ready_o = en;

  assign sq_side_in = {cos_value_i, sin_value_i, axis_x_i, axis_y_i, axis_z_i};

  aar_sqrt #(
    .SideW (SqSW)
  ) u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .axis_x_i (axis_x_i),
    .axis_y_i (axis_y_i),
    .axis_z_i (axis_z_i),
    .side_i   (sq_side_in),
    .valid_o  (sq_vld),
    .root_o   (root),
    .side_o   (sq_side)
  );

  // zero root means zero-length axis
  assign dv_side_in = {root == '0, sq_side[5*DW-1:3*DW]};

  aar_div #(
    .FracBits (FRAC_BITS),
    .SideW    (DvSW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (sq_vld),
    .root_i   (root),
    .axis_x_i (signed'(sq_side[3*DW-1:2*DW])),
    .axis_y_i (signed'(sq_side[2*DW-1:DW])),
    .axis_z_i (signed'(sq_side[DW-1:0])),
    .side_i   (dv_side_in),
    .valid_o  (dv_vld),
    .unit_x_o (ux),
    .unit_y_o (uy),
    .unit_z_o (uz),
    .side_o   (dv_side)
  );

  aar_mat #(
    .FracBits (FRAC_BITS)
  ) u_mat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (dv_vld),
    .unit_x_i (ux),
    .unit_y_i (uy),
    .unit_z_i (uz),
    .cos_i    (signed'(dv_side[2*DW-1:DW])),
    .sin_i    (signed'(dv_side[DW-1:0])),
    .zero_i   (dv_side[2*DW]),
    .valid_o  (mat_vld),
    .ent_o    (ent),
    .zero_o   (axis_zero_o)
  );

  assign out_valid_o = mat_vld;
  assign r0c0_o = ent[0];
  assign r0c1_o = ent[1];
  assign r0c2_o = ent[2];
  assign r1c0_o = ent[3];
  assign r1c1_o = ent[4];
  assign r1c2_o = ent[5];
  assign r2c0_o = ent[6];
  assign r2c1_o = ent[7];
  assign r2c2_o = ent[8];

endmodule

@@ tb/tb_top.sv @@
// Testbench for axis_angle_rotation_matrix: random and directed Rodrigues items,
// checked against a bit-exact fixed-point predictor. Depends on aar_pkg and the RTL.
`timescale 1ns / 1ps

typedef struct {
  logic signed [15:0] ent[9];
  logic               zero;
} matrix_t;

class rot_matrix_board;
  matrix_t pending_q[$];
  int      errors;

  function automatic longint rnd14(longint w);
    return (w + 64'sd8192) >>> 14;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unit_comp(longint a, longint unsigned len);
    longint unsigned mag;
    longint          q;
    mag = longint'(a < 0 ? -a : a) << 30;
    q = longint'((mag + len / 2) / len);
    return a < 0 ? -q : q;
  endfunction

  // bitwise integer square root
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // compute the expected matrix for one accepted item
  function void note_item(longint c, longint s, longint ax, longint ay, longint az);
    matrix_t         m;
    longint unsigned n2, len;
    longint          x, y, z, t, qxx, qyy, qzz, qxy, qxz, qyz, sx, sy, sz;
    longint          e[9];
    n2 = ax * ax + ay * ay + az * az;
    if (n2 == 0) begin
      foreach (m.ent[i]) m.ent[i] = 0;
      m.zero = 1'b1;
    end else begin
      len = isqrt(n2 << 32);
      x = unit_comp(ax, len);
      y = unit_comp(ay, len);
      z = unit_comp(az, len);
      t = 16384 - c;
      qxx = rnd14(rnd14(x * x) * t);
      qyy = rnd14(rnd14(y * y) * t);
      qzz = rnd14(rnd14(z * z) * t);
      qxy = rnd14(rnd14(x * y) * t);
      qxz = rnd14(rnd14(x * z) * t);
      qyz = rnd14(rnd14(y * z) * t);
      sx = rnd14(x * s);
      sy = rnd14(y * s);
      sz = rnd14(z * s);
      e[0] = qxx + c;  e[1] = qxy - sz; e[2] = qxz + sy;
      e[3] = qxy + sz; e[4] = qyy + c;  e[5] = qyz - sx;
      e[6] = qxz - sy; e[7] = qyz + sx; e[8] = qzz + c;
      foreach (e[i]) m.ent[i] = 16'(sat16(e[i]));
      m.zero = 1'b0;
    end
    pending_q.push_back(m);
  endfunction

  function void check_result(matrix_t got);
    matrix_t exp_m;
    if (pending_q.size() == 0) begin
      $display("%0t: result with nothing expected", $realtime);
      errors++;
      return;
    end
    exp_m = pending_q.pop_front();
    for (int i = 0; i < 9; i++)
      if (got.ent[i] !== exp_m.ent[i]) begin
        $display("%0t: entry %0d expected %0d actual %0d", $realtime, i,
                 exp_m.ent[i], got.ent[i]);
        errors++;
      end
    if (got.zero !== exp_m.zero) begin
      $display("%0t: axis_zero expected %0b actual %0b", $realtime, exp_m.zero, got.zero);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int WatchLimit = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o, out_valid_o, axis_zero_o;
  logic signed [15:0] cos_value_i = '0, sin_value_i = '0;
  logic signed [15:0] axis_x_i = '0, axis_y_i = '0, axis_z_i = '0;
  logic signed [15:0] r0c0_o, r0c1_o, r0c2_o, r1c0_o, r1c1_o, r1c2_o, r2c0_o, r2c1_o, r2c2_o;

  rot_matrix_board board = new();
  bit  feed_done = 0;
  bit  hold_off = 0;
  int  idle_cycles = 0;

  axis_angle_rotation_matrix u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // offer one item and wait for its acceptance
  task automatic send_item(logic [15:0] c, logic [15:0] s, logic [15:0] x,
                           logic [15:0] y, logic [15:0] z);
    cos_value_i <= c; sin_value_i <= s;
    axis_x_i <= x; axis_y_i <= y; axis_z_i <= z;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item($signed(c), $signed(s), $signed(x), $signed(y), $signed(z));
  endtask

  task automatic send_random();
    logic [15:0] x, y, z, c, s;
    int          k;
    k = $urandom_range(0, 9);
    x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
    if (k < 3) begin
      x = $signed(x) >>> $urandom_range(0, 15);
      y = $signed(y) >>> $urandom_range(0, 15);
      z = $signed(z) >>> $urandom_range(0, 15);
    end
    if (k == 3) begin
      x = '0; y = '0; z = '0;
    end
    c = 16'($urandom_range(0, 32768) - 16384);
    s = 16'($urandom_range(0, 32768) - 16384);
    if (k == 4) begin
      c = 16'($urandom); s = 16'($urandom);
    end
    send_item(c, s, x, y, z);
  endtask

  // stimulus
  initial begin
    int n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_item(16'sd16384, 16'sd0, 16'sd1, 16'sd0, 16'sd0);
    send_item(-16'sd16384, 16'sd0, 16'sd0, 16'sd1, 16'sd0);
    send_item(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd1);
    send_item(16'sd0, -16'sd16384, 16'sd1, 16'sd1, 16'sd1);
    send_item(16'sd11585, 16'sd11585, 16'h8000, 16'h8000, 16'h8000);
    send_item(16'h8000, 16'h7fff, 16'sd32767, 16'sd32767, 16'sd32767);
    send_item(16'h7fff, 16'h8000, 16'h8000, 16'sd32767, 16'sd0);
    send_item(16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_item(-16'sd16384, -16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_item(16'sd0, 16'sd0, 16'sd3, -16'sd4, 16'sd12);
    send_item(-16'sd5000, 16'sd7000, -16'sd1, 16'sd0, 16'sd0);
    send_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    for (n = 0; n < 1200; n++) begin
      if (n == 300) hold_off = 1;
      if (n < 300 || n > 360) begin
        if (n % 200 > 100) begin
          int g;
          g = gap_len();
          if (g > 0) begin
            in_valid_i <= 1'b0;
            repeat (g) @(posedge clk_i);
          end
        end
      end
      send_random();
    end
    in_valid_i <= 1'b0;
    feed_done = 1;
  end

  // receiver readiness, with one long hold-off
  initial begin
    int g;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off && !held) begin
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        held = 1'b1;
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      matrix_t got;
      got.ent[0] = r0c0_o; got.ent[1] = r0c1_o; got.ent[2] = r0c2_o;
      got.ent[3] = r1c0_o; got.ent[4] = r1c1_o; got.ent[5] = r1c2_o;
      got.ent[6] = r2c0_o; got.ent[7] = r2c1_o; got.ent[8] = r2c2_o;
      got.zero = axis_zero_o;
      board.check_result(got);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (feed_done);
    wait (board.pending_q.size() == 0);
    repeat (80) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
